@@ hdl/gf2r_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and the multiply-by-x helper for the GF(2)
// polynomial reduction block. No dependencies.
package gf2r_pkg;

  localparam int DEGREE    = 64;
  localparam int WORD_W    = 64;
  localparam int PADDR_W   = 4;
  localparam int GROUP     = 4;
  localparam int N1        = (DEGREE + GROUP - 1) / GROUP;
  localparam int N2        = (N1 + GROUP - 1) / GROUP;
  localparam int CNT_W     = $clog2(DEGREE);

  localparam logic [WORD_W-1:0] MODULUS_RST = WORD_W'(27);

  localparam logic REG_MODULUS = 1'b0;

  typedef logic [DEGREE-1:0] poly_t;
  typedef poly_t [DEGREE-1:0] col_mat_t;

  typedef enum logic {
    CG_IDLE,
    CG_BUILD
  } cg_state_e;

  function automatic poly_t times_x(poly_t col, poly_t g_low);
    poly_t r;
    r = {col[DEGREE-2:0], 1'b0} ^ (g_low & {DEGREE{col[DEGREE-1]}});
    return r;
  endfunction

endpackage

@@ hdl/gf2_poly_mod_reduce.sv @@
`timescale 1ns / 1ps
// Top level of the GF(2) polynomial reduction block: APB register and glue.
// Depends on gf2r_pkg, gf2r_col_gen and gf2r_xor_pipe.
//
// Reduces L + x^m H modulo the monic polynomial g of degree m, whose low
// coefficients sit in the modulus register (APB, byte address 0, 64 bits).
// The input channel carries low_half_i and high_half_i; a transfer happens
// when in_valid_i and in_ready_o are both high. The output channel carries
// remainder_o under out_valid_o and out_ready_i.
// The datapath is three register stages of AND-XOR logic, and one item can
// transfer in every cycle while out_ready_i is high and no column build or
// modulus write holds the input. The matrix columns live in flip-flops and
// are rebuilt by repeated multiply-by-x, one column per cycle.
// After reset the modulus is 27 and in_ready_o stays low while the columns
// are built. Each modulus write starts the same build and holds in_ready_o
// low during its access cycle and until the columns are rebuilt.
// When the receiver stalls, the stages fill up and in_ready_o drops; nothing
// is lost or repeated.
module gf2_poly_mod_reduce (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gf2r_pkg::PADDR_W-1:0] paddr,
  input  logic [gf2r_pkg::WORD_W-1:0]  pwdata,
  output logic [gf2r_pkg::WORD_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [gf2r_pkg::WORD_W-1:0]  low_half_i,
  input  logic [gf2r_pkg::WORD_W-1:0]  high_half_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [gf2r_pkg::WORD_W-1:0]  remainder_o
);

  logic [gf2r_pkg::WORD_W-1:0] modulus_q;
  logic                        reg_sel;
  logic                        mod_wr;
  logic                        busy;
  logic                        pipe_ready;
  gf2r_pkg::col_mat_t          cols;
  gf2r_pkg::poly_t             rem;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[gf2r_pkg::PADDR_W-1:3] == gf2r_pkg::REG_MODULUS);
  assign mod_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? modulus_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= gf2r_pkg::MODULUS_RST;
    end else if (mod_wr) begin
      modulus_q <= pwdata;
    end
  end

  gf2r_col_gen u_col_gen (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_wr_i (mod_wr),
    .g_low_i  (modulus_q[gf2r_pkg::DEGREE-1:0]),
    .cols_o   (cols),
    .busy_o   (busy)
  );

  gf2r_xor_pipe u_xor_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cols_i      (cols),
    .hold_i      (busy || mod_wr),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (pipe_ready),
    .low_i       (low_half_i[gf2r_pkg::DEGREE-1:0]),
    .high_i      (high_half_i[gf2r_pkg::DEGREE-1:0]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rem_o       (rem)
  );

  assign in_ready_o  = pipe_ready;
  assign remainder_o = gf2r_pkg::WORD_W'(rem);

endmodule

@@ hdl/gf2r_col_gen.sv @@
`timescale 1ns / 1ps
// Builds the reduction matrix columns x^(m+j) mod g, one column per cycle.
// Depends on gf2r_pkg.
module gf2r_col_gen (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_i,
  input  gf2r_pkg::poly_t    g_low_i,
  output gf2r_pkg::col_mat_t cols_o,
  output logic               busy_o
);

  gf2r_pkg::cg_state_e            state_q, state_d;
  logic [gf2r_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  gf2r_pkg::col_mat_t             cols_q;
  gf2r_pkg::poly_t                new_col;
  logic                           shift_en;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    shift_en = 1'b0;
    case (state_q)
      gf2r_pkg::CG_IDLE: begin
        state_d = gf2r_pkg::CG_IDLE;
      end
      gf2r_pkg::CG_BUILD: begin
        shift_en = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == gf2r_pkg::CNT_W'(gf2r_pkg::DEGREE - 1)) begin
          state_d = gf2r_pkg::CG_IDLE;
        end
      end
      default: begin
        state_d = gf2r_pkg::CG_IDLE;
      end
    endcase
    if (cfg_wr_i) begin
      state_d  = gf2r_pkg::CG_BUILD;
      cnt_d    = '0;
      shift_en = 1'b0;
    end
  end

  assign new_col = (cnt_q == '0) ? g_low_i
                 : gf2r_pkg::times_x(cols_q[gf2r_pkg::DEGREE-1], g_low_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gf2r_pkg::CG_BUILD;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      cols_q <= {new_col, cols_q[gf2r_pkg::DEGREE-1:1]};
    end
  end

  assign cols_o = cols_q;
  assign busy_o = (state_q == gf2r_pkg::CG_BUILD);

  a_build_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gf2r_pkg::CG_BUILD) &&
    (cnt_q == gf2r_pkg::CNT_W'(gf2r_pkg::DEGREE - 1)) && !cfg_wr_i
    |=> state_q == gf2r_pkg::CG_IDLE)
    else $error("column build did not finish after the last column");

  a_cols_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gf2r_pkg::CG_IDLE) && !cfg_wr_i |=> $stable(cols_q))
    else $error("matrix columns changed while idle");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr_i |=> (state_q == gf2r_pkg::CG_BUILD) && (cnt_q == '0))
    else $error("modulus write did not restart the column build");

endmodule

@@ hdl/gf2r_xor_pipe.sv @@
`timescale 1ns / 1ps
// Three-stage AND-XOR pipeline computing L xor M*H with per-stage valid bits.
// Depends on gf2r_pkg.
module gf2r_xor_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gf2r_pkg::col_mat_t cols_i,
  input  logic               hold_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gf2r_pkg::poly_t    low_i,
  input  gf2r_pkg::poly_t    high_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gf2r_pkg::poly_t    rem_o
);

  gf2r_pkg::poly_t p1 [gf2r_pkg::N1];
  gf2r_pkg::poly_t p2 [gf2r_pkg::N2];
  gf2r_pkg::poly_t p3;

  gf2r_pkg::poly_t s1_q [gf2r_pkg::N1];
  gf2r_pkg::poly_t s2_q [gf2r_pkg::N2];
  gf2r_pkg::poly_t low1_q, low2_q, rem_q;
  logic            v1_q, v2_q, v3_q;
  logic            en1, en2, en3;

  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1 && !hold_i;

  always_comb begin
    for (int k = 0; k < gf2r_pkg::N1; k++) begin
      p1[k] = '0;
      for (int g = 0; g < gf2r_pkg::GROUP; g++) begin
        if (k * gf2r_pkg::GROUP + g < gf2r_pkg::DEGREE) begin
          if (high_i[k * gf2r_pkg::GROUP + g]) begin
            p1[k] = p1[k] ^ cols_i[k * gf2r_pkg::GROUP + g];
          end
        end
      end
    end
  end

  always_comb begin
    for (int p = 0; p < gf2r_pkg::N2; p++) begin
      p2[p] = '0;
      for (int g = 0; g < gf2r_pkg::GROUP; g++) begin
        if (p * gf2r_pkg::GROUP + g < gf2r_pkg::N1) begin
          p2[p] = p2[p] ^ s1_q[p * gf2r_pkg::GROUP + g];
        end
      end
    end
  end

  always_comb begin
    p3 = low2_q;
    for (int p = 0; p < gf2r_pkg::N2; p++) begin
      p3 = p3 ^ s2_q[p];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i && in_ready_o;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q   <= p1;
      low1_q <= low_i;
    end
    if (en2) begin
      s2_q   <= p2;
      low2_q <= low1_q;
    end
    if (en3) begin
      rem_q <= p3;
    end
  end

  assign out_valid_o = v3_q;
  assign rem_o       = rem_q;

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted item did not enter the first stage");

  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !en3 |=> v2_q)
    else $error("middle stage lost an item during a stall");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rem_o))
    else $error("waiting remainder dropped or changed");

endmodule
